// ----- sv/art_pkg.sv -----
// Shared types and constants of the activity run table.
// Record layout, request codes, slot status codes and scan result bundle.
// No dependencies.
package art_pkg;

  localparam int ENTRIES   = 64;
  localparam int KEY_BITS  = 64;
  localparam int TIME_BITS = 32;

  localparam int OP_W     = 2;
  localparam int KEY_IN_W = 64;
  localparam int NAME_W   = 64;
  localparam int NOW_IN_W = 32;
  localparam int SLOT_W   = 6;
  localparam int STATE_W  = 2;
  localparam int LIVE_W   = 7;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TM_W  = (TIME_BITS < NOW_IN_W) ? TIME_BITS : NOW_IN_W;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  localparam logic [STATE_W-1:0] ST_EMPTY   = 2'd0;
  localparam logic [STATE_W-1:0] ST_STARTED = 2'd1;
  localparam logic [STATE_W-1:0] ST_DELETED = 2'd2;

  typedef struct packed {
    logic              del;
    logic [TM_W-1:0]   stamp;
    logic [NAME_W-1:0] name;
    logic [KEY_BITS-1:0] key;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             vld;
    logic             live;
    logic [IDX_W-1:0] idx;
  } cmp_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [NAME_W-1:0] hit_name;
    logic              hit_del;
    logic              emp;
    logic [IDX_W-1:0]  emp_idx;
    logic              old;
    logic [IDX_W-1:0]  old_idx;
  } scan_res_t;

endpackage

// ----- sv/art_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data registered. No dependencies.
module art_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/art_scan.sv -----
// Scan tracker of the activity run table: follows one record per cycle and
// keeps the first key match, the first empty slot and the oldest deleted slot.
// Depends on art_pkg.
module art_scan import art_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [TM_W-1:0]     now,
  input  logic [KEY_BITS-1:0] key,
  input  cmp_t                cmp,
  input  rec_t                rec,
  output scan_res_t           res
);

  scan_res_t       res_r;
  logic [TM_W-1:0] old_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.hit <= 1'b0;
      res_r.emp <= 1'b0;
      res_r.old <= 1'b0;
    end else if (start) begin
      res_r.hit  <= 1'b0;
      res_r.emp  <= 1'b0;
      res_r.old  <= 1'b0;
      old_time_r <= now;
    end else if (cmp.vld) begin
      if (cmp.live && !res_r.hit && rec.key == key) begin
        res_r.hit      <= 1'b1;
        res_r.hit_idx  <= cmp.idx;
        res_r.hit_name <= rec.name;
        res_r.hit_del  <= rec.del;
      end
      if (!cmp.live && !res_r.emp) begin
        res_r.emp     <= 1'b1;
        res_r.emp_idx <= cmp.idx;
      end
      if (cmp.live && rec.del && rec.stamp < old_time_r) begin
        res_r.old     <= 1'b1;
        res_r.old_idx <= cmp.idx;
        old_time_r    <= rec.stamp;
      end
    end
  end

  assign res = res_r;

endmodule

// ----- sv/activity_run_table_core.sv -----
// Activity run table: associative table of ENTRIES slots with find, insert
// and delete requests; empty slots are used first, then deleted slots oldest first.
// Depends on art_pkg, art_ram and art_scan.
//
// Usage:
//   Requests enter on in_valid/in_stall with op, key, entry_name and now.
//   A request is taken when in_valid is high and in_stall is low. Results
//   leave on out_valid/out_stall, one result per request.
//   Each request scans the whole record memory through its single read port,
//   one slot per cycle, then passes through a wait step and a write-back
//   step; the result register is loaded at write-back, and the next request
//   is taken only once the previous one has left write-back.
//   in_stall is high while a request is in work.
//   If out_stall holds a previous result, the finished request waits in its
//   write-back step, leaving the table untouched until the result register
//   frees; the result then stays stable until taken.
//   Reset (rst_n low, synchronous) marks every slot empty and clears the
//   started count; it needs no clearing pass, and requests are taken on the
//   first cycle after reset.
module activity_run_table_core import art_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_IN_W-1:0] in_key,
  input  logic [NAME_W-1:0]   in_entry_name,
  input  logic [NOW_IN_W-1:0] in_now,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [NAME_W-1:0]   out_stored_name,
  output logic [STATE_W-1:0]  out_entry_state,
  output logic                out_table_full,
  output logic [LIVE_W-1:0]   out_live_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_WRITE
  } state_t;

  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [NAME_W-1:0]   name_r;
  logic [TM_W-1:0]     now_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [ENTRIES-1:0]  live_r;
  logic [CNT_W-1:0]    cnt_r;
  cmp_t                cmp_r;

  logic                out_valid_r;
  logic                ok_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [NAME_W-1:0]   stored_name_r;
  logic [STATE_W-1:0]  entry_state_r;
  logic                full_r;
  logic [LIVE_W-1:0]   live_count_r;

  logic                accept;
  logic                go;
  logic                scan_start;
  rec_t                rd_rec;
  logic [REC_W-1:0]    rd_data;
  scan_res_t           res;

  logic                do_wr;
  logic [IDX_W-1:0]    wr_idx;
  rec_t                wr_rec;
  logic                set_live;
  logic                cnt_up;
  logic                cnt_dn;
  logic                r_ok;
  logic                r_full;
  logic                r_show;
  logic [IDX_W-1:0]    r_idx;
  logic [NAME_W-1:0]   r_name;
  logic [STATE_W-1:0]  r_state;
  logic [CNT_W-1:0]    cnt_nxt;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign go         = (state_r == S_WRITE) && (!out_valid_r || !out_stall);
  assign scan_start = (state_r == S_SCAN) && (rd_idx_r == '0) && !cmp_r.vld;
  assign rd_rec     = rec_t'(rd_data);

  art_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (REC_W)
  ) u_ram (
    .clk   (clk),
    .we    (go && do_wr),
    .waddr (wr_idx),
    .wdata (wr_rec),
    .re    (state_r == S_SCAN),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  art_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .now   (now_r),
    .key   (key_r),
    .cmp   (cmp_r),
    .rec   (rd_rec),
    .res   (res)
  );

  always_comb begin
    do_wr       = 1'b0;
    wr_idx      = res.hit_idx;
    wr_rec.del  = res.hit_del;
    wr_rec.stamp = now_r;
    wr_rec.name = res.hit_name;
    wr_rec.key  = key_r;
    set_live    = 1'b0;
    cnt_up      = 1'b0;
    cnt_dn      = 1'b0;
    r_ok        = 1'b0;
    r_full      = 1'b0;
    r_show      = res.hit;
    r_idx       = res.hit_idx;
    r_name      = res.hit_name;
    r_state     = res.hit_del ? ST_DELETED : ST_STARTED;
    case (op_r)
      OP_FIND: begin
        do_wr = res.hit;
        r_ok  = res.hit;
      end
      OP_INSERT: begin
        if (res.hit) begin
          do_wr = 1'b1;
        end else if (res.emp || res.old) begin
          do_wr       = 1'b1;
          wr_idx      = res.emp ? res.emp_idx : res.old_idx;
          wr_rec.del  = 1'b0;
          wr_rec.name = name_r;
          set_live    = 1'b1;
          cnt_up      = 1'b1;
          r_ok        = 1'b1;
          r_show      = 1'b1;
          r_idx       = res.emp ? res.emp_idx : res.old_idx;
          r_name      = name_r;
          r_state     = ST_STARTED;
        end else begin
          r_full = 1'b1;
        end
      end
      OP_DELETE: begin
        if (res.hit) begin
          do_wr      = 1'b1;
          wr_rec.del = 1'b1;
          cnt_dn     = !res.hit_del && (cnt_r != '0);
          r_ok       = 1'b1;
          r_state    = ST_DELETED;
        end
      end
      default: begin
        r_show = 1'b0;
      end
    endcase
    if (cnt_up) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cnt_dn) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      cnt_r       <= '0;
      cmp_r.vld   <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
    end else begin
      cmp_r.vld  <= (state_r == S_SCAN);
      cmp_r.idx  <= rd_idx_r;
      cmp_r.live <= live_r[rd_idx_r];
      if (out_valid_r && !out_stall && !go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_op;
            key_r    <= in_key[KEY_BITS-1:0];
            name_r   <= in_entry_name;
            now_r    <= in_now[TM_W-1:0];
            rd_idx_r <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= S_WAIT;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_WAIT: begin
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (go) begin
            if (set_live) begin
              live_r[wr_idx] <= 1'b1;
            end
            cnt_r         <= cnt_nxt;
            out_valid_r   <= 1'b1;
            ok_r          <= r_ok;
            full_r        <= r_full;
            slot_r        <= r_show ? SLOT_W'(r_idx) : '0;
            stored_name_r <= r_show ? r_name : '0;
            entry_state_r <= r_show ? r_state : ST_EMPTY;
            live_count_r  <= LIVE_W'(cnt_nxt);
            rd_idx_r      <= '0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_slot        = slot_r;
  assign out_stored_name = stored_name_r;
  assign out_entry_state = entry_state_r;
  assign out_table_full  = full_r;
  assign out_live_count  = live_count_r;

endmodule

// ----- sv/art_checker.sv -----
// Port-level checks of the activity run table, bound to the top level.
// Depends on art_pkg and activity_run_table_core.
module art_checker import art_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_ok,
  input logic [SLOT_W-1:0]   out_slot,
  input logic [NAME_W-1:0]   out_stored_name,
  input logic [STATE_W-1:0]  out_entry_state,
  input logic                out_table_full,
  input logic [LIVE_W-1:0]   out_live_count
);

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_slot)
      && $stable(out_stored_name) && $stable(out_live_count))
    else $error("stalled request result changed");

  a_full_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_ok && out_entry_state == ST_EMPTY)
    else $error("full table reported with a slot");

  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_entry_state != ST_EMPTY)
    else $error("successful request reports an empty slot");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_state == ST_EMPTY |-> out_slot == '0 && out_stored_name == '0)
    else $error("no slot involved but slot fields not zero");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind activity_run_table_core art_checker u_art_checker (.*);
